// ===== src/tcon_pkg.sv =====
// Shared types, constants and the scancode table of the text console.
package tcon_pkg;

   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int TAB_WIDTH      = 8;
   localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;
   localparam int SHIFT_COUNT    = CELL_COUNT - SCREEN_COLUMNS;
   localparam int QUEUE_DEPTH    = 2;

   localparam int ROW_W  = $clog2(SCREEN_ROWS);
   localparam int COL_W  = $clog2(SCREEN_COLUMNS + 1);
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int POS_W  = 11;
   localparam int CMP_W  = 8;
   localparam int CELL_W = 16;

   // operation codes
   localparam logic [1:0] OP_SCANCODE = 2'd0;
   localparam logic [1:0] OP_HOST     = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;
   localparam logic [1:0] OP_READ     = 2'd3;

   // register indexes
   localparam logic CSR_COLOR = 1'b0;
   localparam logic CSR_FLOOR = 1'b1;

   localparam logic [7:0] COLOR_RESET = 8'd18;
   localparam logic [6:0] FLOOR_RESET = 7'd8;

   // scancodes
   localparam logic [7:0] SC_EXTENDED = 8'hE0;
   localparam logic [7:0] SC_UP       = 8'h48;
   localparam logic [7:0] SC_DOWN     = 8'h50;
   localparam logic [7:0] SC_LEFT     = 8'h4B;
   localparam logic [7:0] SC_RIGHT    = 8'h4D;

   // control characters
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam logic [CELL_W-1:0] RESET_CELL = {COLOR_RESET, CH_SPACE};

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_UP,
      CMD_DOWN,
      CMD_LEFT,
      CMD_RIGHT,
      CMD_NEWLINE,
      CMD_BACKSPACE,
      CMD_TAB,
      CMD_PUT,
      CMD_CLEAR,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  code;
      logic [10:0] read_address;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [7:0]  cell_character;
      logic [7:0]  cell_color;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch;
      logic [10:0]  addr;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef struct packed {
      logic [7:0] color;
      logic [6:0] floor;
   } cfg_type;

   // Set-1 make codes; bit 8 marks a key that has a character.
   function automatic logic [8:0] key_lookup(input logic [7:0] sc);
      logic [8:0] r;
      r = 9'h000;
      case (sc)
         8'd1:    r = {1'b1, 8'h1B};
         8'd2:    r = {1'b1, 8'h31};
         8'd3:    r = {1'b1, 8'h32};
         8'd4:    r = {1'b1, 8'h33};
         8'd5:    r = {1'b1, 8'h34};
         8'd6:    r = {1'b1, 8'h35};
         8'd7:    r = {1'b1, 8'h36};
         8'd8:    r = {1'b1, 8'h37};
         8'd9:    r = {1'b1, 8'h38};
         8'd10:   r = {1'b1, 8'h39};
         8'd11:   r = {1'b1, 8'h30};
         8'd12:   r = {1'b1, 8'h2D};
         8'd13:   r = {1'b1, 8'h3D};
         8'd14:   r = {1'b1, CH_BACKSPACE};
         8'd15:   r = {1'b1, CH_TAB};
         8'd16:   r = {1'b1, 8'h71};
         8'd17:   r = {1'b1, 8'h77};
         8'd18:   r = {1'b1, 8'h65};
         8'd19:   r = {1'b1, 8'h72};
         8'd20:   r = {1'b1, 8'h74};
         8'd21:   r = {1'b1, 8'h79};
         8'd22:   r = {1'b1, 8'h75};
         8'd23:   r = {1'b1, 8'h69};
         8'd24:   r = {1'b1, 8'h6F};
         8'd25:   r = {1'b1, 8'h70};
         8'd26:   r = {1'b1, 8'h5B};
         8'd27:   r = {1'b1, 8'h5D};
         8'd28:   r = {1'b1, 8'h00};
         8'd30:   r = {1'b1, 8'h61};
         8'd31:   r = {1'b1, 8'h73};
         8'd32:   r = {1'b1, 8'h64};
         8'd33:   r = {1'b1, 8'h66};
         8'd34:   r = {1'b1, 8'h67};
         8'd35:   r = {1'b1, 8'h68};
         8'd36:   r = {1'b1, 8'h6A};
         8'd37:   r = {1'b1, 8'h6B};
         8'd38:   r = {1'b1, 8'h6C};
         8'd39:   r = {1'b1, 8'h3B};
         8'd40:   r = {1'b1, 8'h27};
         8'd41:   r = {1'b1, 8'h60};
         8'd43:   r = {1'b1, 8'h5C};
         8'd44:   r = {1'b1, 8'h7A};
         8'd45:   r = {1'b1, 8'h78};
         8'd46:   r = {1'b1, 8'h63};
         8'd47:   r = {1'b1, 8'h76};
         8'd48:   r = {1'b1, 8'h62};
         8'd49:   r = {1'b1, 8'h6E};
         8'd50:   r = {1'b1, 8'h6D};
         8'd51:   r = {1'b1, 8'h2C};
         8'd52:   r = {1'b1, 8'h2E};
         8'd53:   r = {1'b1, 8'h2F};
         8'd57:   r = {1'b1, CH_SPACE};
         default: r = 9'h000;
      endcase
      return r;
   endfunction

   function automatic cmd_kind_type char_kind(input logic [7:0] ch);
      cmd_kind_type k;
      case (ch)
         CH_NEWLINE:   k = CMD_NEWLINE;
         CH_BACKSPACE: k = CMD_BACKSPACE;
         CH_TAB:       k = CMD_TAB;
         default:      k = CMD_PUT;
      endcase
      return k;
   endfunction

endpackage

// ===== src/tcon_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcon_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tcon_front.sv =====
// Front end: decode scancodes and host characters into console commands.
module tcon_front
   import tcon_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    push,
   output cmd_type cmd
);

   logic       prefix_ff;
   logic       prefix_in;
   logic [8:0] key;

   always_comb begin
      prefix_in = prefix_ff;
      key       = key_lookup(req.code);
      cmd.kind  = CMD_NOP;
      cmd.ch    = req.code;
      cmd.addr  = req.read_address;
      if (accept) begin
         case (req.operation)
            OP_SCANCODE: begin
               if (prefix_ff) begin
                  // any code consumes the prefix; arrow keys move the cursor, anything else is dropped
                  prefix_in = 1'b0;
                  case (req.code)
                     SC_UP:    cmd.kind = CMD_UP;
                     SC_DOWN:  cmd.kind = CMD_DOWN;
                     SC_LEFT:  cmd.kind = CMD_LEFT;
                     SC_RIGHT: cmd.kind = CMD_RIGHT;
                     default:  cmd.kind = CMD_NOP;
                  endcase
               end else if (req.code == SC_EXTENDED) begin
                  prefix_in = 1'b1;
               end else if (key[8]) begin
                  cmd.ch   = key[7:0];
                  cmd.kind = char_kind(key[7:0]);
               end
            end
            OP_HOST:  cmd.kind = char_kind(req.code);
            OP_CLEAR: cmd.kind = CMD_CLEAR;
            OP_READ:  cmd.kind = CMD_READ;
            default:  cmd.kind = CMD_NOP;
         endcase
      end
   end

   assign push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
      end
   end

endmodule

// ===== src/tcon_queue.sv =====
// Short command queue between the decode front end and the screen engine.
module tcon_queue
   import tcon_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_cmd,
   input  logic       pop,
   output q_head_type head,
   output logic       full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/tcon_back.sv =====
// Screen engine: cursor, cell memory, scroll, clear and cell reads.
module tcon_back
   import tcon_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_head_type head,
   input  cfg_type    cfg,
   output logic       pop,
   output logic       init_busy,
   output logic       rsp_strobe,
   output rsp_type    rsp_word
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_BLANK,
      ST_CLEAR
   } state_type;

   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(SHIFT_COUNT);

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic              put_ff, put_in;
   logic [7:0]        put_ch_ff, put_ch_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;

   logic              done;
   logic              rd_hit;
   logic [ADDR_W-1:0] cur_addr;
   logic [ADDR_W-1:0] next_row_addr;
   logic [COL_W:0]    tab_sum;
   logic [CELL_W-1:0] blank;

   tcon_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cur_addr      = ADDR_W'(row_ff) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col_ff);
   assign next_row_addr = ADDR_W'(row_ff + 1'b1) * ADDR_W'(SCREEN_COLUMNS);
   assign tab_sum       = (COL_W + 1)'(col_ff) + (COL_W + 1)'(TAB_WIDTH);
   assign blank         = {cfg.color, CH_SPACE};

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      put_in        = put_ff;
      put_ch_in     = put_ch_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = cur_addr;
      wr_data       = blank;
      rd_addr       = head.cmd.addr[ADDR_W-1:0];
      done          = 1'b0;
      rd_hit        = 1'b0;

      case (state_ff)
         ST_INIT: begin
            // sweep the reset pattern through every cell
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = RESET_CELL;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.cmd.kind)
                  CMD_NOP: done = 1'b1;
                  CMD_UP: begin
                     if (row_ff != '0) begin
                        row_in = row_ff - 1'b1;
                     end
                     done = 1'b1;
                  end
                  CMD_DOWN: begin
                     if (row_ff < LAST_ROW) begin
                        row_in = row_ff + 1'b1;
                     end
                     done = 1'b1;
                  end
                  CMD_LEFT: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end
                     done = 1'b1;
                  end
                  CMD_RIGHT: begin
                     if (col_ff < COL_W'(SCREEN_COLUMNS - 1)) begin
                        col_in = col_ff + 1'b1;
                     end
                     done = 1'b1;
                  end
                  CMD_NEWLINE: begin
                     col_in = '0;
                     if (row_ff < LAST_ROW) begin
                        row_in = row_ff + 1'b1;
                        done   = 1'b1;
                     end else begin
                        put_in   = 1'b0;
                        cnt_in   = '0;
                        pend_in  = 1'b0;
                        state_in = ST_SCROLL;
                     end
                  end
                  CMD_BACKSPACE: begin
                     if (CMP_W'(col_ff) > CMP_W'(cfg.floor)) begin
                        col_in  = col_ff - 1'b1;
                        wr_en   = 1'b1;
                        wr_addr = cur_addr - 1'b1;
                     end
                     done = 1'b1;
                  end
                  CMD_TAB: begin
                     if (tab_sum > (COL_W + 1)'(SCREEN_COLUMNS)) begin
                        col_in = COL_W'(SCREEN_COLUMNS);
                     end else begin
                        col_in = tab_sum[COL_W-1:0];
                     end
                     done = 1'b1;
                  end
                  CMD_PUT: begin
                     if (col_ff >= COL_W'(SCREEN_COLUMNS)) begin
                        // wrap first
                        if (row_ff < LAST_ROW) begin
                           row_in  = row_ff + 1'b1;
                           col_in  = COL_W'(1);
                           wr_en   = 1'b1;
                           wr_addr = next_row_addr;
                           wr_data = {cfg.color, head.cmd.ch};
                           done    = 1'b1;
                        end else begin
                           // scroll, then drop the character into the fresh row
                           put_in    = 1'b1;
                           put_ch_in = head.cmd.ch;
                           col_in    = '0;
                           cnt_in    = '0;
                           pend_in   = 1'b0;
                           state_in  = ST_SCROLL;
                        end
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = {cfg.color, head.cmd.ch};
                        col_in  = col_ff + 1'b1;
                        done    = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_READ: begin
                     if (head.cmd.addr < 11'(CELL_COUNT)) begin
                        state_in = ST_READ;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: done = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            done     = 1'b1;
            rd_hit   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            // read one row ahead, write back in the next cycle
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff - 1'b1;
               wr_data = rd_data;
            end
            rd_addr = cnt_ff + ADDR_W'(SCREEN_COLUMNS);
            if (cnt_ff < ADDR_W'(SHIFT_COUNT)) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  cnt_in   = '0;
                  state_in = ST_BLANK;
               end
            end
         end
         ST_BLANK: begin
            wr_en   = 1'b1;
            wr_addr = LAST_BASE + cnt_ff;
            if (put_ff && (cnt_ff == '0)) begin
               wr_data = {cfg.color, put_ch_ff};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(SCREEN_COLUMNS - 1)) begin
               col_in   = put_ff ? COL_W'(1) : '0;
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               row_in   = '0;
               col_in   = '0;
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (done) begin
         rsp_strobe_in          = 1'b1;
         rsp_in.cursor_position = POS_W'(row_in) * POS_W'(SCREEN_COLUMNS) + POS_W'(col_in);
         rsp_in.cell_character  = rd_hit ? rd_data[7:0] : 8'h00;
         rsp_in.cell_color      = rd_hit ? rd_data[15:8] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         row_ff        <= '0;
         col_ff        <= '0;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         put_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         put_ff        <= put_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      put_ch_ff <= put_ch_in;
      rsp_ff    <= rsp_in;
   end

   assign init_busy  = (state_ff == ST_INIT);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== src/text_console_with_keyboard_decode.sv =====
// Top level of the text console with set-1 keyboard decode.
//
//  channel   ports                           direction  flow
//  request   start, busy, req_word           in         taken when start && !busy
//  response  rsp_strobe, rsp_word            out        one-cycle strobe, no backpressure
//  config    csr_we, csr_index, csr_data     in         written when csr_we is high
//
// A simple word (cursor move, tab, backspace, plain character, NOP) is carried
// out when the screen engine takes it from the queue; a cell read waits in a
// read state for the registered read of the cell memory. A newline or wrap on
// the last row costs a scroll sweep that copies every lower row up by one,
// then a blank pass over the last row; a clear sweeps every cell. The cell
// memory has one write port, and these sweeps go through it one cell per cycle.
// After reset an init pass fills every cell with blanks; busy is held high
// through it. Otherwise busy rises only when the two-entry command queue is
// full. Results cannot be stalled.
module text_console_with_keyboard_decode
   import tcon_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_word,
   output logic       rsp_strobe,
   output rsp_type    rsp_word,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       accept;
   logic       push;
   cmd_type    push_cmd;
   logic       pop;
   q_head_type head;
   logic       q_full;
   logic       init_busy;

   // Hold new requests off while the queue is full or the memory is still
   // being filled after reset.
   assign busy   = q_full || init_busy;
   assign accept = start && !busy;

   // Configuration registers: write on enable, no read-back.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COLOR: cfg_in.color = csr_data;
            CSR_FLOOR: cfg_in.floor = csr_data[6:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color <= COLOR_RESET;
         cfg_ff.floor <= FLOOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Decode: scancodes and host characters become console commands.
   tcon_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_word),
      .push   (push),
      .cmd    (push_cmd)
   );

   // Decouple decode from the screen engine so intake goes on during sweeps until the queue is full.
   tcon_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (q_full)
   );

   // Execute: move the cursor, write, scroll, clear and read cells.
   tcon_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .cfg        (cfg_ff),
      .pop        (pop),
      .init_busy  (init_busy),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule
